/* src/lpe_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants and divider handshake types for the Legendre evaluator.
// No dependencies.
package lpe_pkg;

  localparam int FRAC_BITS  = 30;
  localparam int RECIP_BITS = 32;
  localparam int DEG_W      = 7;
  localparam int POINT_W    = 32;
  localparam int SLOPE_W    = 48;
  localparam int DEN_W      = FRAC_BITS + 1;
  localparam int NM_W       = 40;
  localparam int DIV_NUM_W  = NM_W + FRAC_BITS;
  localparam int Q_W        = SLOPE_W + 1;
  localparam int QUO_W      = SLOPE_W + 2;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DEN_W-1:0]     den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* src/lpe_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider for the slope: rounded quotient with overflow flag.
// Depends on lpe_pkg.
module lpe_div import lpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r;
  logic                 fin_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] num_sh_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [Q_W-1:0]       q_r;
  logic                 ovf_r;
  logic [QUO_W-1:0]     quo_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic [Q_W-1:0]   q_nxt;
  logic             ovf_nxt;
  logic             rnd;

  assign rem_sh  = {rem_r, num_sh_r[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
  assign q_nxt   = {q_r[Q_W-2:0], ge};
  assign ovf_nxt = ovf_r | q_r[Q_W-1];
  assign rnd     = {rem_r, 1'b0} >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= CNT_W'(DIV_NUM_W - 1);
        num_sh_r <= req.num;
        den_r    <= req.den;
        rem_r    <= '0;
        q_r      <= '0;
        ovf_r    <= 1'b0;
      end else if (busy_r) begin
        num_sh_r <= num_sh_r << 1;
        rem_r    <= rem_nxt;
        q_r      <= q_nxt;
        ovf_r    <= ovf_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        quo_r  <= {1'b0, q_r} + QUO_W'(rnd);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = quo_r;

endmodule

/* src/legendre_poly_eval.sv */
`timescale 1ns / 1ps
// Legendre polynomial P_n(x) and derivative evaluator, top level.
// Depends on lpe_pkg and lpe_div.
//
// Usage:
//   Write the degree n on cfg_degree with cfg_valid; cfg_ready is high while idle.
//   Present a point x (signed Q2.30) on in_point and raise start; the beat is taken
//   at an edge where start is high and busy is low. busy stays high until the result.
//   The result (P_n as Q2.30, P_n' as saturated Q18.30, endpoint flag) appears for
//   one cycle with out_valid; the receiver has no way to stall it. busy drops in
//   that same cycle, so the next beat may follow right away.
// Sequence (accept to out_valid):
//   degree 0 or 1: the sequencer goes straight from idle to the result state.
//   degree n >= 2: n-1 recurrence steps, each with 5 passes through the one
//   33x32 multiplier; the slope then runs through the bit-serial divider
//   (70 quotient bits, rounding, done). At x = +/-1 the divider is skipped.
// Reset: degree returns to 1, the sequencer to idle, no result pending.
module legendre_poly_eval import lpe_pkg::*; #(
  parameter int MAX_DEGREE = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [POINT_W-1:0] in_point,
  output logic                      out_valid,
  output logic signed [POINT_W-1:0] out_poly_value,
  output logic signed [SLOPE_W-1:0] out_poly_slope,
  output logic                      out_endpoint_flag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [DEG_W-1:0]          cfg_degree
);

  localparam int N_MAX  = (MAX_DEGREE > 127) ? 127 : MAX_DEGREE;
  localparam int IDX_W  = $clog2(N_MAX + 1);
  localparam int MA_W   = 33;
  localparam int MB_W   = 32;
  localparam int PR_W   = MA_W + MB_W;
  localparam int ACC_W  = 74;
  localparam int NUM_W  = 42;

  localparam logic signed [POINT_W-1:0] X_HI = POINT_W'(64'd1 << FRAC_BITS);
  localparam logic signed [POINT_W-1:0] X_LO = -X_HI;
  localparam logic [MB_W-1:0] P_POS_MAX = MB_W'((64'd1 << (FRAC_BITS + 1)) - 64'd1);
  localparam logic [MB_W-1:0] P_NEG_MAX = MB_W'(64'd1 << (FRAC_BITS + 1));
  localparam logic [SLOPE_W-1:0] S_POS_MAX = SLOPE_W'((64'd1 << (SLOPE_W - 1)) - 64'd1);
  localparam logic [SLOPE_W-1:0] S_NEG_MAX = SLOPE_W'(64'd1 << (SLOPE_W - 1));

  typedef enum logic [4:0] {
    ST_IDLE, ST_XP1, ST_T, ST_N1, ST_N2, ST_NMAG, ST_R0, ST_R1, ST_R2, ST_P,
    ST_SQ, ST_SQR, ST_DIFF, ST_DMAG, ST_NMUL, ST_NLD, ST_DIV, ST_FIN
  } state_t;

  // reciprocal ROM, round(2^32 / i)
  logic [RECIP_BITS-1:0] recip_tab [N_MAX+1];
  for (genvar g = 0; g <= N_MAX; g++) begin : g_recip
    localparam logic [RECIP_BITS-1:0] RV =
      (g < 2) ? '0 : RECIP_BITS'(((64'd1 << RECIP_BITS) + g / 2) / g);
    assign recip_tab[g] = RV;
  end

  state_t                   state_r;
  logic                     busy_r;
  logic [DEG_W-1:0]         degree_r;
  logic [IDX_W-1:0]         n_r;
  logic [IDX_W-1:0]         i_r;
  logic [FRAC_BITS:0]       x_mag_r;
  logic                     x_neg_r;
  logic [MB_W-1:0]          p1_mag_r;
  logic                     p1_neg_r;
  logic [MB_W-1:0]          p2_mag_r;
  logic                     p2_neg_r;
  logic [MB_W-1:0]          t_mag_r;
  logic                     t_neg_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [NUM_W-2:0]         nmag_r;
  logic                     nneg_r;
  logic [ACC_W-1:0]         acc_r;
  logic [PR_W-1:0]          prod_r;
  logic [DEN_W-1:0]         den_mag_r;
  logic signed [MA_W:0]     diff_r;
  logic [MA_W-1:0]          dmag_r;
  logic                     sneg_r;
  logic                     flag_r;
  logic [SLOPE_W-1:0]       slope_r;
  logic                     out_valid_r;
  logic [POINT_W-1:0]       out_value_r;
  logic [SLOPE_W-1:0]       out_slope_r;
  logic                     out_flag_r;

  logic [MA_W-1:0]          mul_a;
  logic [MB_W-1:0]          mul_b;
  logic [RECIP_BITS-1:0]    recip;
  logic [PR_W-1:0]          prod_rnd;
  logic [PR_W-FRAC_BITS-1:0] prod_q;
  logic [ACC_W-33:0]        pm;
  logic [MB_W-1:0]          p_mag_nxt;
  logic [FRAC_BITS:0]       x_mag_nxt;
  logic                     x_neg_nxt;
  logic [IDX_W-1:0]         n_nxt;
  logic signed [MA_W:0]     xp_s;
  logic signed [MA_W:0]     p2_neg_s;
  logic [SLOPE_W-1:0]       q_clip;
  logic [MB_W:0]            p_val;
  logic                     accept;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign accept = start && !busy_r;
  assign recip  = recip_tab[i_r];

  // input clamp to [-1, 1]
  always_comb begin
    if (in_point < X_LO) begin
      x_mag_nxt = X_HI[FRAC_BITS:0];
      x_neg_nxt = 1'b1;
    end else if (in_point > X_HI) begin
      x_mag_nxt = X_HI[FRAC_BITS:0];
      x_neg_nxt = 1'b0;
    end else begin
      x_mag_nxt = in_point[POINT_W-1] ? (FRAC_BITS+1)'(-in_point)
                                      : in_point[FRAC_BITS:0];
      x_neg_nxt = in_point[POINT_W-1];
    end
  end

  assign n_nxt = (degree_r > DEG_W'(N_MAX)) ? IDX_W'(N_MAX) : degree_r[IDX_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_XP1: begin
        mul_a = {2'b0, x_mag_r};
        mul_b = p1_mag_r;
      end
      ST_T: begin
        mul_a = {1'b0, p2_mag_r};
        mul_b = MB_W'(i_r) - 1'b1;
      end
      ST_N1: begin
        mul_a = {1'b0, t_mag_r};
        mul_b = MB_W'({i_r, 1'b0}) - 1'b1;
      end
      ST_R0: begin
        mul_a = nmag_r[MA_W-1:0];
        mul_b = recip;
      end
      ST_R1: begin
        mul_a = MA_W'(nmag_r[NUM_W-2:MA_W]);
        mul_b = recip;
      end
      ST_SQ: begin
        mul_a = {2'b0, x_mag_r};
        mul_b = {1'b0, x_mag_r};
      end
      ST_SQR: begin
        mul_a = {2'b0, x_mag_r};
        mul_b = p1_mag_r;
      end
      ST_NMUL: begin
        mul_a = dmag_r;
        mul_b = MB_W'(n_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod_rnd = prod_r + (PR_W'(1) << (FRAC_BITS - 1));
  assign prod_q   = prod_rnd[PR_W-1:FRAC_BITS];

  // P_i magnitude after rounding by the reciprocal, saturated
  assign pm = acc_r[ACC_W-1:32];
  always_comb begin
    if (nneg_r) p_mag_nxt = (pm > (ACC_W-32)'(P_NEG_MAX)) ? P_NEG_MAX : pm[MB_W-1:0];
    else        p_mag_nxt = (pm > (ACC_W-32)'(P_POS_MAX)) ? P_POS_MAX : pm[MB_W-1:0];
  end

  assign xp_s     = x_neg_r ^ p1_neg_r ? -(MA_W+1)'(prod_q[MB_W-1:0])
                                       : (MA_W+1)'(prod_q[MB_W-1:0]);
  assign p2_neg_s = p2_neg_r ? (MA_W+1)'(p2_mag_r) : -(MA_W+1)'(p2_mag_r);

  always_comb begin
    if (sneg_r) q_clip = (div_rsp.ovf || div_rsp.quo > QUO_W'(S_NEG_MAX)) ? S_NEG_MAX
                                                        : div_rsp.quo[SLOPE_W-1:0];
    else        q_clip = (div_rsp.ovf || div_rsp.quo > QUO_W'(S_POS_MAX)) ? S_POS_MAX
                                                        : div_rsp.quo[SLOPE_W-1:0];
  end

  assign p_val = p1_neg_r ? -{1'b0, p1_mag_r} : {1'b0, p1_mag_r};

  assign div_req.start = (state_r == ST_NLD);
  assign div_req.num   = {prod_r[NM_W-1:0], {FRAC_BITS{1'b0}}};
  assign div_req.den   = den_mag_r;

  lpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      degree_r    <= DEG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) degree_r <= cfg_degree;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            busy_r   <= 1'b1;
            n_r      <= n_nxt;
            i_r      <= IDX_W'(2);
            x_mag_r  <= x_mag_nxt;
            x_neg_r  <= x_neg_nxt;
            flag_r   <= 1'b0;
            p2_mag_r <= MB_W'(X_HI);
            p2_neg_r <= 1'b0;
            if (n_nxt == '0) begin
              p1_mag_r <= MB_W'(X_HI);
              p1_neg_r <= 1'b0;
              slope_r  <= '0;
              state_r  <= ST_FIN;
            end else if (n_nxt == IDX_W'(1)) begin
              p1_mag_r <= MB_W'(x_mag_nxt);
              p1_neg_r <= x_neg_nxt;
              slope_r  <= SLOPE_W'(X_HI);
              state_r  <= ST_FIN;
            end else begin
              p1_mag_r <= MB_W'(x_mag_nxt);
              p1_neg_r <= x_neg_nxt;
              slope_r  <= '0;
              state_r  <= ST_XP1;
            end
          end
        end
        ST_XP1: state_r <= ST_T;
        ST_T: begin
          t_mag_r <= prod_q[MB_W-1:0];
          t_neg_r <= x_neg_r ^ p1_neg_r;
          state_r <= ST_N1;
        end
        ST_N1: begin
          num_r   <= p2_neg_r ? NUM_W'(prod_r) : -NUM_W'(prod_r);
          state_r <= ST_N2;
        end
        ST_N2: begin
          num_r   <= t_neg_r ? num_r - NUM_W'(prod_r) : num_r + NUM_W'(prod_r);
          state_r <= ST_NMAG;
        end
        ST_NMAG: begin
          nmag_r  <= num_r[NUM_W-1] ? (NUM_W-1)'(-num_r) : num_r[NUM_W-2:0];
          nneg_r  <= num_r[NUM_W-1];
          state_r <= ST_R0;
        end
        ST_R0: state_r <= ST_R1;
        ST_R1: begin
          acc_r   <= ACC_W'(prod_r);
          state_r <= ST_R2;
        end
        ST_R2: begin
          acc_r   <= acc_r + (ACC_W'(prod_r) << MA_W) + (ACC_W'(1) << (RECIP_BITS - 1));
          state_r <= ST_P;
        end
        ST_P: begin
          p2_mag_r <= p1_mag_r;
          p2_neg_r <= p1_neg_r;
          p1_mag_r <= p_mag_nxt;
          p1_neg_r <= nneg_r;
          if (i_r == n_r) begin
            state_r <= ST_SQ;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= ST_XP1;
          end
        end
        ST_SQ: state_r <= ST_SQR;
        ST_SQR: begin
          den_mag_r <= DEN_W'(X_HI) - prod_q[DEN_W-1:0];
          flag_r    <= prod_q[DEN_W-1:0] == DEN_W'(X_HI);
          state_r   <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_r  <= xp_s + p2_neg_s;
          state_r <= flag_r ? ST_FIN : ST_DMAG;
        end
        ST_DMAG: begin
          dmag_r  <= diff_r[MA_W] ? MA_W'(-diff_r) : diff_r[MA_W-1:0];
          sneg_r  <= !diff_r[MA_W] && (diff_r != '0);
          state_r <= ST_NMUL;
        end
        ST_NMUL: state_r <= ST_NLD;
        ST_NLD:  state_r <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            slope_r <= sneg_r ? -q_clip : q_clip;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_valid_r <= 1'b1;
          out_value_r <= p_val[POINT_W-1:0];
          out_slope_r <= slope_r;
          out_flag_r  <= flag_r;
          busy_r      <= 1'b0;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy              = busy_r;
  assign cfg_ready         = !busy_r;
  assign out_valid         = out_valid_r;
  assign out_poly_value    = out_value_r;
  assign out_poly_slope    = out_slope_r;
  assign out_endpoint_flag = out_flag_r;

  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_endpoint_slope: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flag_r) |-> (out_slope_r == '0))
    else $error("endpoint result with nonzero slope");

  a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> busy_r)
    else $error("sequencer active while not busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside of divide wait");

endmodule

/* tb/legendre_poly_eval_chk.sv */
`timescale 1ns / 1ps
// Checker for legendre_poly_eval: tracks the degree register, predicts P_n(x), the
// saturated slope and the endpoint flag per point, and compares each result beat.
// Depends on lpe_pkg.
module legendre_poly_eval_chk import lpe_pkg::*; #(
  parameter int MAX_DEGREE = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [POINT_W-1:0] in_point,
  input  logic                      out_valid,
  input  logic signed [POINT_W-1:0] out_poly_value,
  input  logic signed [SLOPE_W-1:0] out_poly_slope,
  input  logic                      out_endpoint_flag,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [DEG_W-1:0]          cfg_degree,
  output int                        errors,
  output int                        pending,
  output int                        n_checked,
  output int                        n_endpoint
);

  typedef struct packed {
    logic signed [POINT_W-1:0] value;
    logic signed [SLOPE_W-1:0] slope;
    logic                      flag;
  } leg_res_t;

  leg_res_t         leg_q[$];
  leg_res_t         want;
  logic [DEG_W-1:0] cur_degree;

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // magnitude product, rounded half away from zero, capped at 2^62
  function automatic longint round_mul(input longint a, input longint b, input int sh);
    logic [127:0] prod;
    logic [63:0]  res;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    prod = (prod + (128'd1 << (sh - 1))) >> sh;
    res  = (prod > (128'd1 << 62)) ? (64'd1 << 62) : prod[63:0];
    return neg ? -$signed(res) : $signed(res);
  endfunction

  function automatic leg_res_t eval_point(input logic signed [POINT_W-1:0] pt,
                                          input logic [DEG_W-1:0] deg);
    leg_res_t     r;
    longint       one, lim, x, p, p1, p2, t, num, recip, den, diff;
    int           n, i;
    logic [63:0]  nm, dv;
    logic [127:0] numer, quo, rem;
    one = longint'(1) << FRAC_BITS;
    lim = longint'(1) << (FRAC_BITS + 1);
    x = pt;
    if (x > one) x = one;
    if (x < -one) x = -one;
    n = (deg > MAX_DEGREE) ? MAX_DEGREE : int'(deg);
    r.flag  = 1'b0;
    r.slope = '0;
    p = one;
    if (n == 1) begin
      p = x;
      r.slope = SLOPE_W'(one);
    end else if (n >= 2) begin
      p1 = x;
      p2 = one;
      for (i = 2; i <= n; i++) begin
        recip = ((longint'(1) << RECIP_BITS) + i / 2) / i;
        t   = round_mul(x, p1, FRAC_BITS);
        num = longint'(2 * i - 1) * t - longint'(i - 1) * p2;
        p   = round_mul(num, recip, RECIP_BITS);
        if (p > lim - 1) p = lim - 1;
        else if (p < -lim) p = -lim;
        p2 = p1;
        p1 = p;
      end
      den = round_mul(x, x, FRAC_BITS) - one;
      if (den == 0) begin
        r.flag = 1'b1;
      end else begin
        diff  = round_mul(x, p, FRAC_BITS) - p2;
        nm    = 64'(n) * abs64(diff);
        dv    = abs64(den);
        numer = {64'd0, nm} << FRAC_BITS;
        quo   = numer / {64'd0, dv};
        rem   = numer % {64'd0, dv};
        if ((rem << 1) >= {64'd0, dv}) quo = quo + 1;
        // x^2 - 1 is negative, so the sign follows -diff
        if (diff > 0) begin
          if (quo > (128'd1 << (SLOPE_W - 1))) quo = 128'd1 << (SLOPE_W - 1);
          r.slope = -quo[SLOPE_W-1:0];
        end else begin
          if (quo > (128'd1 << (SLOPE_W - 1)) - 1) quo = (128'd1 << (SLOPE_W - 1)) - 1;
          r.slope = quo[SLOPE_W-1:0];
        end
      end
    end
    r.value = p[POINT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      leg_q.delete();
      cur_degree = 1;
      errors     = 0;
      pending    = 0;
      n_checked  = 0;
      n_endpoint = 0;
    end else begin
      if (out_valid) begin
        if (leg_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result beat with nothing expected: value %h slope %h flag %b",
                     $realtime, out_poly_value, out_poly_slope, out_endpoint_flag);
        end else begin
          want = leg_q.pop_front();
          if (out_poly_value !== want.value || out_poly_slope !== want.slope ||
              out_endpoint_flag !== want.flag) begin
            errors++;
            if (errors <= 10)
              $display("[%0t] mismatch: value %h/%h slope %h/%h flag %b/%b (exp/got)",
                       $realtime, want.value, out_poly_value, want.slope, out_poly_slope,
                       want.flag, out_endpoint_flag);
          end
        end
        n_checked++;
        if (out_endpoint_flag) n_endpoint++;
      end
      if (start && !busy) leg_q.push_back(eval_point(in_point, cur_degree));
      if (cfg_valid && cfg_ready) cur_degree = cfg_degree;
      pending = leg_q.size();
    end
  end

endmodule

/* tb/legendre_poly_eval_tb.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for legendre_poly_eval: degree settings, directed and random points.
// Depends on lpe_pkg, legendre_poly_eval and legendre_poly_eval_chk.
module legendre_poly_eval_tb import lpe_pkg::*;;

  localparam int WATCHDOG = 5000;
  localparam logic signed [POINT_W-1:0] Q_ONE     = 32'sh4000_0000;
  localparam logic signed [POINT_W-1:0] Q_NEG_ONE = -32'sh4000_0000;
  localparam logic signed [POINT_W-1:0] Q_HALF    = 32'sh2000_0000;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [POINT_W-1:0] in_point;
  logic                      out_valid;
  logic signed [POINT_W-1:0] out_poly_value;
  logic signed [SLOPE_W-1:0] out_poly_slope;
  logic                      out_endpoint_flag;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [DEG_W-1:0]          cfg_degree;

  int errors, pending, n_checked, n_endpoint;
  int n_sent, n_cfg, idle_cycles, failures, gap_max, beats;

  legendre_poly_eval u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_point(in_point),
    .out_valid(out_valid), .out_poly_value(out_poly_value),
    .out_poly_slope(out_poly_slope), .out_endpoint_flag(out_endpoint_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_degree(cfg_degree)
  );

  legendre_poly_eval_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_point(in_point),
    .out_valid(out_valid), .out_poly_value(out_poly_value),
    .out_poly_slope(out_poly_slope), .out_endpoint_flag(out_endpoint_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_degree(cfg_degree),
    .errors(errors), .pending(pending), .n_checked(n_checked), .n_endpoint(n_endpoint)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("legendre_poly_eval test failed");
        $finish;
      end
    end
  end

  // stop sending and wait until every expected result is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic set_degree(input logic [DEG_W-1:0] d);
    drain();
    cfg_valid  = 1'b1;
    cfg_degree = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_cfg++;
  endtask

  // start is left high after the beat; the next call lowers or reuses it
  task automatic send_point(input logic signed [POINT_W-1:0] pt, input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    = 1'b1;
    in_point = pt;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  function automatic logic signed [POINT_W-1:0] pick_point();
    longint v;
    case ($urandom_range(0, 9))
      0: v = Q_ONE;
      1: v = Q_NEG_ONE;
      2: v = longint'(Q_ONE) - $urandom_range(1, 1000);
      3: v = longint'(Q_NEG_ONE) + $urandom_range(1, 1000);
      4: v = $urandom;
      5: v = longint'($urandom_range(0, 2047)) - 1024;
      default: v = longint'($urandom_range(0, 32'h8000_0000)) - longint'(Q_ONE);
    endcase
    return v[POINT_W-1:0];
  endfunction

  function automatic logic [DEG_W-1:0] pick_degree();
    case ($urandom_range(0, 9))
      0: return DEG_W'($urandom_range(0, 1));
      1: return DEG_W'($urandom_range(40, 127));
      2: return DEG_W'(64);
      default: return DEG_W'($urandom_range(2, 20));
    endcase
  endfunction

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_point   = '0;
    cfg_valid  = 1'b0;
    cfg_degree = '0;
    n_sent     = 0;
    n_cfg      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset degree is 1
    send_point(Q_HALF, 2);
    set_degree(0);
    send_point(Q_ONE, 2);
    send_point(32'sh7FFF_FFFF, 2);
    send_point(32'sh0000_0000, 0);
    set_degree(1);
    send_point(Q_NEG_ONE, 2);
    send_point(32'sh8000_0000, 0);
    send_point(32'sh1234_5678, 1);
    set_degree(2);
    send_point(Q_ONE, 2);
    send_point(Q_NEG_ONE, 0);
    send_point(32'sh0000_0000, 0);
    send_point(Q_ONE - 1, 2);
    send_point(-Q_HALF, 1);
    set_degree(127);
    send_point(Q_ONE, 2);
    send_point(Q_NEG_ONE, 0);
    send_point(Q_ONE - 1, 0);
    send_point(Q_NEG_ONE + 1, 3);
    send_point(32'sh7FFF_FFFF, 0);
    send_point(32'sh8000_0000, 2);
    send_point(32'sh0000_0001, 0);
    set_degree(65);
    send_point(32'sh3A00_0000, 1);
    send_point(-32'sh3A00_0000, 0);
    drain();

    while (n_sent < 420) begin
      set_degree(pick_degree());
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      beats   = $urandom_range(15, 50);
      repeat (beats) begin
        if ($urandom_range(0, 29) == 0) drain();
        send_point(pick_point(), gap_max);
      end
    end

    drain();
    repeat (700) @(posedge clk);
    @(negedge clk);
    failures = errors + pending;
    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Checked %0d results from %0d points over %0d degree settings, %0d at x = +/-1",
             n_checked, n_sent, n_cfg, n_endpoint);
    if (failures == 0) begin
      $display("legendre_poly_eval test passed");
    end else begin
      $display("legendre_poly_eval test failed");
    end
    $finish;
  end

endmodule
